// ===== rtl/randomized_hash_set_defines.svh =====
// ----------------------------------------------------------------------------
// randomized hash set assertion macros
// concurrent assertion helpers clocked on clk_i, quiet during reset
// ----------------------------------------------------------------------------
`ifndef RANDOMIZED_HASH_SET_DEFINES_SVH
`define RANDOMIZED_HASH_SET_DEFINES_SVH

`ifndef SYNTHESIS
`define RHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RHS_ASSERT(lbl, prop, msg)
`define RHS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/rhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rhs_pkg
// shared types, codes and constants of the randomized hash set
// ----------------------------------------------------------------------------
package rhs_pkg;

  localparam int DEF_NUM_BUCKETS = 1063;
  localparam int DEF_CAPACITY    = 256;

  localparam int KEY_W  = 32;
  localparam int RND_W  = 31;
  localparam int BKT_W  = 11;
  localparam int DIV_W  = 11;
  localparam int DVD_W  = 32;
  localparam int GRP_SZ = 16;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_PICK     = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [RND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic             result_flag;
    logic [KEY_W-1:0] picked_key;
    logic [1:0]       error_code;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       mod_start;
    logic       ins;
    logic       del;
    logic       emit;
    logic       flag;
    logic [1:0] err;
    logic       use_pick;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       full;
    logic       empty;
    logic       mod_done;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/randomized_hash_set.sv =====
// ----------------------------------------------------------------------------
// randomized hash set
// set of distinct signed keys with insert, remove, contains and random pick
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  request  | in_valid_i / in_stall_o   | in_req_i  (op, key, random_value)
//  response | out_valid_o / out_stall_i | out_rsp_o (result_flag, picked_key,
//           |                           |            error_code)
//
// steps from acceptance to the loading of the response:
// contains, absent remove, duplicate or full insert run the search, remove and
// insert then update the cell chain (bucket comes from a three stage reciprocal
// pipeline during the search), pick runs the remainder by the element count
// and then the two-level select tree, a pick on an empty set skips both
// one request at a time; a new request is taken as soon as the previous
// response sits in the output register, even while that response is stalled
// reset clears the element count and the handshake state; cells need no clear
// ----------------------------------------------------------------------------
`include "randomized_hash_set_defines.svh"

module randomized_hash_set #(
  parameter int NUM_BUCKETS = rhs_pkg::DEF_NUM_BUCKETS,
  parameter int CAPACITY    = rhs_pkg::DEF_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rhs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rhs_pkg::rsp_t out_rsp_o
);

  // command and status between sequencer and datapath
  rhs_pkg::cmd_t cmd;
  rhs_pkg::sts_t sts;

  // sequencer: dispatches the request, waits on search or remainder unit
  rhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: bucket-sorted cell chain, match tree, remainder, output reg
  rhs_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CAPACITY    (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // a request is only taken while the sequencer is idle
  `RHS_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o,
    "request accepted while busy")
  // an error response never reports success
  `RHS_ASSERT_IMP(a_err_no_flag, out_valid_o && out_rsp_o.error_code != rhs_pkg::ERR_NONE,
    !out_rsp_o.result_flag, "error response with flag set")
  // a picked key only comes with a successful pick
  `RHS_ASSERT_IMP(a_key_needs_flag, out_valid_o && out_rsp_o.picked_key != '0,
    out_rsp_o.result_flag, "picked key without flag")
  // the set is never both full and empty
  `RHS_ASSERT(a_count_sane, !(sts.full && sts.empty), "count full and empty")

endmodule

// ===== rtl/rhs_mod.sv =====
// ----------------------------------------------------------------------------
// rhs_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rhs_mod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rhs_pkg::DVD_W-1:0] dividend_i,
  input  logic [rhs_pkg::DIV_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [rhs_pkg::DIV_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(rhs_pkg::DVD_W);

  logic                      busy_q, done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [rhs_pkg::DVD_W-1:0] dvd_q;
  logic [rhs_pkg::DIV_W-1:0] div_q, rem_q, rem_d;
  logic [rhs_pkg::DIV_W:0]   trial;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, dvd_q[rhs_pkg::DVD_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = rhs_pkg::DIV_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[rhs_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(rhs_pkg::DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[rhs_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/rhs_dp.sv =====
// ----------------------------------------------------------------------------
// rhs_dp
// sorted cell chain, search tree, remainder unit and result register
// ----------------------------------------------------------------------------
module rhs_dp #(
  parameter int NUM_BUCKETS = rhs_pkg::DEF_NUM_BUCKETS,
  parameter int CAPACITY    = rhs_pkg::DEF_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rhs_pkg::req_t in_req_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output rhs_pkg::rsp_t out_rsp_o,
  input  rhs_pkg::cmd_t cmd_i,
  output rhs_pkg::sts_t sts_o
);

  localparam int IW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int GROUPS = (CAPACITY + rhs_pkg::GRP_SZ - 1) / rhs_pkg::GRP_SZ;
  localparam int KW     = rhs_pkg::KEY_W;

  // reciprocal of the bucket count, exact quotient for any 32 bit magnitude
  localparam int          BL    = $clog2(NUM_BUCKETS);
  localparam int          RS    = rhs_pkg::DVD_W + BL;
  localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'(NUM_BUCKETS) - 64'd1)
                                  / 64'(NUM_BUCKETS);
  localparam logic [32:0] RC    = RECIP[32:0];
  localparam logic [15:0] RC_LO = RC[15:0];
  localparam logic [16:0] RC_HI = RC[32:16];

  logic [1:0]                op_q;
  logic [KW-1:0]             key_q;
  logic [rhs_pkg::RND_W-1:0] rnd_q;
  logic [CW-1:0]             count_q;

  logic [KW-1:0]             cell_key_q [CAPACITY];
  logic [rhs_pkg::BKT_W-1:0] cell_bkt_q [CAPACITY];

  logic [CAPACITY-1:0] sel, lt;

  logic [GROUPS-1:0] g_hit_d, g_hit_q;
  logic [KW-1:0]     g_key_d [GROUPS];
  logic [KW-1:0]     g_key_q [GROUPS];
  logic [IW-1:0]     g_idx_d [GROUPS];
  logic [IW-1:0]     g_idx_q [GROUPS];
  logic              t_hit_d, t_hit_q;
  logic [KW-1:0]     t_key_d, t_key_q;
  logic [IW-1:0]     t_idx_d, t_idx_q;

  logic [rhs_pkg::DVD_W-1:0] mag, dividend;
  logic [rhs_pkg::DIV_W-1:0] divisor, rem;
  logic                      mod_done;
  logic [IW-1:0]             pick_pos;
  logic [rhs_pkg::BKT_W-1:0] new_bkt;

  logic [47:0]               bk_plo_q;
  logic [48:0]               bk_phi_q;
  logic [64:0]               bk_sum;
  logic [31:0]               bk_quo_q, bk_prod, bk_rem;
  logic [rhs_pkg::BKT_W-1:0] bkt_q;

  logic          out_valid_q;
  rhs_pkg::rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_req_i.op;
      key_q <= in_req_i.key;
      rnd_q <= in_req_i.random_value;
    end
  end

  // magnitude of the key; the most negative key maps to 2^31
  assign mag      = key_q[KW-1] ? (~key_q + 1'b1) : key_q;
  assign dividend = {1'b0, rnd_q};
  assign divisor  = rhs_pkg::DIV_W'(count_q);

  // bucket pipeline: quotient by reciprocal, then key magnitude mod bucket count
  assign bk_sum  = {17'd0, bk_plo_q} + {bk_phi_q, 16'd0};
  assign bk_prod = bk_quo_q * 32'(NUM_BUCKETS);
  assign bk_rem  = mag - bk_prod;

  always_ff @(posedge clk_i) begin
    bk_plo_q <= {16'd0, mag} * {32'd0, RC_LO};
    bk_phi_q <= {17'd0, mag} * {32'd0, RC_HI};
    bk_quo_q <= 32'(bk_sum >> RS);
    bkt_q    <= bk_rem[rhs_pkg::BKT_W-1:0];
  end

  rhs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  assign pick_pos = rem[IW-1:0];
  assign new_bkt  = bkt_q;

  // per cell select and insert compare
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (op_q == rhs_pkg::OP_PICK) begin
        sel[i] = (pick_pos == IW'(i));
      end else begin
        sel[i] = (CW'(i) < count_q) && (cell_key_q[i] == key_q);
      end
      lt[i] = (CW'(i) < count_q) && (cell_bkt_q[i] < new_bkt);
    end
  end

  // first tree level: and-or inside each group of cells
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      g_hit_d[g] = 1'b0;
      g_key_d[g] = '0;
      g_idx_d[g] = '0;
      for (int j = 0; j < rhs_pkg::GRP_SZ; j++) begin
        if (g * rhs_pkg::GRP_SZ + j < CAPACITY) begin
          if (sel[g * rhs_pkg::GRP_SZ + j]) begin
            g_hit_d[g] = 1'b1;
            g_key_d[g] = g_key_d[g] | cell_key_q[g * rhs_pkg::GRP_SZ + j];
            g_idx_d[g] = g_idx_d[g] | IW'(g * rhs_pkg::GRP_SZ + j);
          end
        end
      end
    end
  end

  // second tree level over the group registers
  always_comb begin
    t_hit_d = 1'b0;
    t_key_d = '0;
    t_idx_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      t_hit_d = t_hit_d | g_hit_q[g];
      t_key_d = t_key_d | g_key_q[g];
      t_idx_d = t_idx_d | g_idx_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    g_hit_q <= g_hit_d;
    g_key_q <= g_key_d;
    g_idx_q <= g_idx_d;
    t_hit_q <= t_hit_d;
    t_key_q <= t_key_d;
    t_idx_q <= t_idx_d;
  end

  // cell chain: insert opens a gap, remove closes one
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd_i.ins && !lt[i]) begin
        if (i == 0) begin
          cell_key_q[i] <= key_q;
          cell_bkt_q[i] <= new_bkt;
        end else if (lt[(i == 0) ? 0 : i - 1]) begin
          cell_key_q[i] <= key_q;
          cell_bkt_q[i] <= new_bkt;
        end else begin
          cell_key_q[i] <= cell_key_q[(i == 0) ? 0 : i - 1];
          cell_bkt_q[i] <= cell_bkt_q[(i == 0) ? 0 : i - 1];
        end
      end else if (cmd_i.del && (IW'(i) >= t_idx_q) && (i + 1 < CAPACITY)) begin
        cell_key_q[i] <= cell_key_q[(i + 1 < CAPACITY) ? i + 1 : i];
        cell_bkt_q[i] <= cell_bkt_q[(i + 1 < CAPACITY) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.del) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.result_flag <= cmd_i.flag;
      out_q.picked_key  <= cmd_i.use_pick ? t_key_q : '0;
      out_q.error_code  <= cmd_i.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign sts_o.op       = op_q;
  assign sts_o.hit      = t_hit_q;
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.mod_done = mod_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/rhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhs_ctrl
// operation sequencer of the randomized hash set
// ----------------------------------------------------------------------------
module rhs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rhs_pkg::sts_t sts_i,
  output rhs_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_TREE1  = 4'd2;
  localparam logic [3:0] S_TREE2  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_MODW   = 4'd5;
  localparam logic [3:0] S_INS    = 4'd6;
  localparam logic [3:0] S_DEL    = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       flag_q, flag_d, pick_q, pick_d;
  logic [1:0] err_q, err_d;

  always_comb begin
    state_d   = state_q;
    flag_d    = flag_q;
    pick_d    = pick_q;
    err_d     = err_q;
    cmd_o     = '0;
    cmd_o.flag     = flag_q;
    cmd_o.err      = err_q;
    cmd_o.use_pick = pick_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          flag_d     = 1'b0;
          pick_d     = 1'b0;
          err_d      = rhs_pkg::ERR_NONE;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.op == rhs_pkg::OP_PICK) begin
          if (sts_i.empty) begin
            err_d   = rhs_pkg::ERR_EMPTY;
            state_d = S_EMIT;
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d         = S_MODW;
          end
        end else begin
          state_d = S_TREE1;
        end
      end
      S_TREE1: state_d = S_TREE2;
      S_TREE2: state_d = S_DECIDE;
      S_DECIDE: begin
        case (sts_i.op)
          rhs_pkg::OP_INSERT: begin
            if (sts_i.hit) begin
              state_d = S_EMIT;
            end else if (sts_i.full) begin
              err_d   = rhs_pkg::ERR_FULL;
              state_d = S_EMIT;
            end else begin
              state_d = S_INS;
            end
          end
          rhs_pkg::OP_REMOVE: begin
            state_d = sts_i.hit ? S_DEL : S_EMIT;
          end
          rhs_pkg::OP_CONTAINS: begin
            flag_d  = sts_i.hit;
            state_d = S_EMIT;
          end
          default: begin
            flag_d  = 1'b1;
            pick_d  = 1'b1;
            state_d = S_EMIT;
          end
        endcase
      end
      S_MODW: begin
        if (sts_i.mod_done) begin
          state_d = S_TREE1;
        end
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        flag_d    = 1'b1;
        state_d   = S_EMIT;
      end
      S_DEL: begin
        cmd_o.del = 1'b1;
        flag_d    = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flag_q  <= 1'b0;
      pick_q  <= 1'b0;
      err_q   <= rhs_pkg::ERR_NONE;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      pick_q  <= pick_d;
      err_q   <= err_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== bench/tb_randomized_hash_set.sv =====
// ----------------------------------------------------------------------------
// randomized hash set testbench
// drives insert, remove, contains and pick requests with random idling on
// both channels and checks every response against a behavioral model of the
// bucket-ordered set
// ----------------------------------------------------------------------------
module tb_randomized_hash_set;
  import rhs_pkg::*;

  localparam int NBKT      = DEF_NUM_BUCKETS;
  localparam int CAP       = DEF_CAPACITY;
  localparam int WDOG_MAX  = 20000;
  localparam int TAIL_CYC  = 60;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  req_t  in_req_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  rsp_t  out_rsp_o;

  randomized_hash_set u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // idling phase: 0 none, 1 sender idle, 2 receiver stalls, 3 both
  int    idle_pct_tx = 0;
  int    idle_pct_rx = 0;
  bit    hold_tx = 1'b0;       // sender paused while this is set

  req_t  pending_reqs[$];      // requests waiting for the driver
  rsp_t  expected_rsps[$];     // predicted responses, oldest first

  // set model: keys in rank order with their buckets
  logic [31:0] set_key[CAP];
  logic [10:0] set_bkt[CAP];
  int          set_count = 0;
  logic [31:0] shadow_keys[$]; // key queue, declared but unused by the stimulus

  int n_sent = 0, n_got = 0, n_err = 0, wdog = 0;
  int n_pick_ok = 0, n_full = 0, n_empty = 0;

  function automatic logic [10:0] bucket_of_key(logic [31:0] k);
    longint r;
    r = longint'($signed(k)) % NBKT;
    if (r < 0) r = -r;
    return r[10:0];
  endfunction

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < set_count; i++)
      if (set_key[i] == k) return i;
    return -1;
  endfunction

  // apply one request to the model and return its response
  function automatic rsp_t apply_to_set(req_t r);
    rsp_t        s;
    int          pos;
    logic [10:0] b;
    s = '0;
    s.error_code = ERR_NONE;
    case (r.op)
      OP_INSERT: begin
        if (find_key(r.key) < 0) begin
          if (set_count >= CAP) begin
            s.error_code = ERR_FULL;
          end else begin
            b = bucket_of_key(r.key);
            pos = 0;
            while (pos < set_count && set_bkt[pos] < b) pos++;
            for (int i = set_count; i > pos; i--) begin
              set_key[i] = set_key[i-1];
              set_bkt[i] = set_bkt[i-1];
            end
            set_key[pos] = r.key;
            set_bkt[pos] = b;
            set_count++;
            s.result_flag = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        pos = find_key(r.key);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < set_count; i++) begin
            set_key[i] = set_key[i+1];
            set_bkt[i] = set_bkt[i+1];
          end
          set_count--;
          s.result_flag = 1'b1;
        end
      end
      OP_CONTAINS: s.result_flag = (find_key(r.key) >= 0);
      default: begin
        if (set_count == 0) begin
          s.error_code = ERR_EMPTY;
        end else begin
          s.picked_key = set_key[int'(r.random_value) % set_count];
          s.result_flag = 1'b1;
        end
      end
    endcase
    return s;
  endfunction

  // driver: prediction happens at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(apply_to_set(in_req_i));
        n_sent++;
      end
      if ((!in_valid_i || !in_stall_o)) begin
        if (pending_reqs.size() > 0 && !hold_tx &&
            $urandom_range(99, 0) >= idle_pct_tx) begin
          in_req_i   <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < idle_pct_rx);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid_o && !out_stall_i) begin
        n_got++;
        if (expected_rsps.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_rsp_o.result_flag !== exp_rsp.result_flag ||
              out_rsp_o.picked_key !== exp_rsp.picked_key ||
              out_rsp_o.error_code !== exp_rsp.error_code) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch on response %0d: expected %p, got %p",
                       n_got, exp_rsp, out_rsp_o);
          end
          if (exp_rsp.error_code == ERR_FULL) n_full++;
          if (exp_rsp.error_code == ERR_EMPTY) n_empty++;
          if (exp_rsp.result_flag && exp_rsp.picked_key != 0) n_pick_ok++;
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // random key: mostly from a small pool so hits and bucket collisions occur
  function automatic logic [31:0] rand_key();
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return 32'h8000_0000 ^ $urandom_range(3, 0);
      2: return $urandom_range(20, 0) * NBKT - 2 * NBKT * $urandom_range(1, 0);
      default: return $signed($urandom_range(80, 0)) - 40;
    endcase
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [31:0] k, logic [30:0] rv);
    req_t r;
    r.op = op;
    r.key = k;
    r.random_value = rv;
    return r;
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid_i);
    while (expected_rsps.size() != 0 || (in_valid_i)) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  task automatic add_random(int n, bit fill_mode);
    logic [31:0] k;
    logic [1:0]  op;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(3, 0));
      if (fill_mode && $urandom_range(3, 0) != 0) op = OP_INSERT;
      k = rand_key();
      if (fill_mode) k = $urandom();
      pending_reqs.push_back(mk_req(op, k, 31'($urandom())));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pick, extremes, duplicates, absent removals, bucket order
    pending_reqs.push_back(mk_req(OP_PICK, 32'h0, 31'h7fff_ffff));
    pending_reqs.push_back(mk_req(OP_CONTAINS, 32'h8000_0000, 31'h0));
    pending_reqs.push_back(mk_req(OP_REMOVE, 32'h7fff_ffff, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'h8000_0000, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'h7fff_ffff, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'h0, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'hffff_ffff, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'd1, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'd1063, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, -32'sd1063, 31'h0));
    pending_reqs.push_back(mk_req(OP_INSERT, 32'd1, 31'h0));
    pending_reqs.push_back(mk_req(OP_CONTAINS, 32'hffff_ffff, 31'h0));
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(mk_req(OP_PICK, $urandom(), i == 0 ? 31'h7fff_ffff : 31'(i)));
    pending_reqs.push_back(mk_req(OP_REMOVE, 32'h0, 31'h0));
    pending_reqs.push_back(mk_req(OP_REMOVE, 32'h0, 31'h0));
    pending_reqs.push_back(mk_req(OP_PICK, 32'h0, 31'h5555_5555));
    pending_reqs.push_back(mk_req(OP_CONTAINS, 32'd1063, 31'h0));

    // wait for every directed response, then pause the sender with hold_tx
    hold_tx = 1'b0;
    drain();
    hold_tx = 1'b1;
    repeat (5) @(posedge clk_i);
    hold_tx = 1'b0;

    // four idling phases of random traffic
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_tx = (ph == 1 || ph == 3) ? (ph == 3 ? 23 : 87) : 0;
      idle_pct_rx = (ph == 2 || ph == 3) ? (ph == 3 ? 23 : 87) : 0;
      add_random(60, 1'b0);
      drain();
    end

    // fill to capacity, exercise full-set inserts, then empty it again
    idle_pct_tx = 0;
    idle_pct_rx = 10;
    add_random(290, 1'b1);
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(mk_req(OP_INSERT, $urandom(), 31'h0));
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(mk_req(OP_PICK, 32'h0, 31'($urandom())));
    drain();
    while (set_count > 0) begin
      for (int i = 0; i < set_count; i++)
        pending_reqs.push_back(mk_req(OP_REMOVE, set_key[i], 31'($urandom())));
      drain();
    end
    pending_reqs.push_back(mk_req(OP_PICK, 32'hffff_ffff, 31'h7fff_ffff));
    drain();

    $display("covered %0d requests, %0d nonzero picks, %0d full inserts, %0d empty picks",
             n_sent, n_pick_ok, n_full, n_empty);
    if (n_err == 0 && expected_rsps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d responses missing", n_err, expected_rsps.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
